@@ hw/rtl/fcpu_pkg.sv @@
// Fly camera pose update: shared widths, command codes and the sine sample function.
// Used by the interfaces, the sine ROM, the axis step and the top level.
`default_nettype none

package fcpu_pkg;

    localparam int unsigned POS_W = 32;
    localparam int unsigned ANG_W = 16;
    localparam int unsigned AMT_W = 16;
    localparam int unsigned WGT_W = 16;

    localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

    // Quarter of a turn in binary angle units; cos(a) = sin(a + QUARTER_TURN).
    localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;

    // Command kinds.
    localparam logic OP_MOVE   = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    // Move directions.
    localparam logic [1:0] MOVE_FORWARD  = 2'd0;
    localparam logic [1:0] MOVE_BACKWARD = 2'd1;
    localparam logic [1:0] MOVE_LEFT     = 2'd2;
    localparam logic [1:0] MOVE_RIGHT    = 2'd3;

    // Rotate directions.
    localparam logic [1:0] ROT_UP    = 2'd0;
    localparam logic [1:0] ROT_DOWN  = 2'd1;
    localparam logic [1:0] ROT_LEFT  = 2'd2;
    localparam logic [1:0] ROT_RIGHT = 2'd3;

    // Per-axis step control.
    typedef struct packed {
        logic en;   // axis takes a step
        logic neg;  // step uses the negated magnitude
    } axis_ctl_t;

    // Q1.15 sine of a binary angle from the quarter-wave polynomial.
    function automatic logic signed [WGT_W-1:0] quarter_poly(input logic [ANG_W-1:0] s);
        logic [1:0]  q;
        logic [31:0] r;
        logic [31:0] x2;
        logic [31:0] t;
        logic [31:0] v;
        logic [WGT_W-1:0] mag;
        q = s[15:14];
        r = {18'd0, s[13:0]};
        if (q[0])
        begin
            r = 32'd16384 - r;
        end
        x2 = (r * r) >> 14;
        t  = 32'd10581 - ((x2 * 32'd1229) >> 14);
        t  = 32'd25736 - ((x2 * t) >> 14);
        v  = (r * t) >> 13;
        if (v > 32'd32767)
        begin
            v = 32'd32767;
        end
        mag = v[WGT_W-1:0];
        return q[1] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fcpu_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one move or rotate item.
// Depends on fcpu_pkg for field widths.
`default_nettype none

interface fcpu_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic [1:0]                            way;
    logic signed [fcpu_pkg::AMT_W-1:0]     amount;

    modport source (output valid, output op, output way, output amount, input ready);
    modport sink   (input valid, input op, input way, input amount, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fcpu_pose_if.sv @@
// Pose channel: valid/ready handshake carrying the camera pose after each item.
// Depends on fcpu_pkg for field widths.
`default_nettype none

interface fcpu_pose_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fcpu_pkg::POS_W-1:0]     pos_x;
    logic signed [fcpu_pkg::POS_W-1:0]     pos_y;
    logic signed [fcpu_pkg::POS_W-1:0]     pos_z;
    logic [fcpu_pkg::ANG_W-1:0]            pitch;
    logic [fcpu_pkg::ANG_W-1:0]            yaw;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output pitch, output yaw, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input pitch, input yaw, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fcpu_sine_rom.sv @@
// Sine sample ROM with one registered read port, indexed by a binary angle.
// Depends on fcpu_pkg for the sample function and widths.
`default_nettype none

module fcpu_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = fcpu_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic [fcpu_pkg::ANG_W-1:0]           angle,
    output logic signed [fcpu_pkg::WGT_W-1:0]    sample
);

    localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned PROD_W = fcpu_pkg::ANG_W + $clog2(SINE_TABLE_DEPTH + 1);

    logic signed [fcpu_pkg::WGT_W-1:0] sine_rom [SINE_TABLE_DEPTH];
    logic [PROD_W-1:0]                 scaled_angle;
    logic [IDX_W-1:0]                  idx;
    logic signed [fcpu_pkg::WGT_W-1:0] sample_reg;

    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++)
    begin : g_entry
        localparam int unsigned SampleAngle = (i * 65536) / SINE_TABLE_DEPTH;
        assign sine_rom[i] = fcpu_pkg::quarter_poly(fcpu_pkg::ANG_W'(SampleAngle));
    end

    // Table index is floor(angle * depth / 65536).
    assign scaled_angle = PROD_W'(angle) * PROD_W'(SINE_TABLE_DEPTH);
    assign idx          = scaled_angle[fcpu_pkg::ANG_W +: IDX_W];

    always_ff @(posedge clk)
    begin
        sample_reg <= sine_rom[idx];
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fcpu_axis_step.sv @@
// One position axis: weighted step, rounding to Q16.16 and saturating add.
// Depends on fcpu_pkg for widths and the axis control struct.
`default_nettype none

module fcpu_axis_step (
    input  logic signed [fcpu_pkg::POS_W-1:0]    base,
    input  logic signed [fcpu_pkg::AMT_W-1:0]    amount,
    input  logic signed [fcpu_pkg::WGT_W-1:0]    weight,
    input  fcpu_pkg::axis_ctl_t                  ctl,
    output logic signed [fcpu_pkg::POS_W-1:0]    result
);

    logic signed [31:0]                prod;
    logic signed [31:0]                prod_dir;
    logic signed [31:0]                biased;
    logic [24:0]                       step;
    logic [fcpu_pkg::POS_W:0]          total;

    // Q8.8 times Q1.15 stays within 31 bits, so negation cannot overflow.
    assign prod     = 32'(amount) * 32'(weight);
    assign prod_dir = ctl.neg ? -prod : prod;
    assign biased   = prod_dir + 32'sd64;
    assign step     = biased[31:7];
    assign total    = {base[fcpu_pkg::POS_W-1], base} + {{8{step[24]}}, step};

    always_comb
    begin
        if (!ctl.en)
        begin
            result = base;
        end
        else if (total[fcpu_pkg::POS_W] != total[fcpu_pkg::POS_W-1])
        begin
            // Clamp to the signed range on overflow.
            result = total[fcpu_pkg::POS_W] ? {1'b1, {(fcpu_pkg::POS_W-1){1'b0}}}
                                            : {1'b0, {(fcpu_pkg::POS_W-1){1'b1}}};
        end
        else
        begin
            result = total[fcpu_pkg::POS_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fly_camera_pose_update.sv @@
// Fly camera pose keeper: position Q16.16, pitch and yaw binary angles; one pose per command.
// Items pass the input stage, then the pose registers; 1 item per cycle unless pose stalls.
// The pose registers double as the result register; sine/cosine come from three ROM
// read ports addressed by the next angles, so they always match the held pose.
// Reset (rst_n low, async): pose and angles clear to zero, both stages go empty.
// Depends on fcpu_pkg, fcpu_cmd_if, fcpu_pose_if, fcpu_sine_rom, fcpu_axis_step.
`default_nettype none

module fly_camera_pose_update #(
    parameter int unsigned SINE_TABLE_DEPTH = fcpu_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    fcpu_cmd_if.sink           cmd,
    fcpu_pose_if.source        pose
);

    // Input stage.
    logic                              cmd_vld_reg;
    logic                              op_reg;
    logic [1:0]                        way_reg;
    logic signed [fcpu_pkg::AMT_W-1:0] amount_reg;

    // Pose state, which is also the result held on the output side.
    logic                              out_vld_reg;
    logic signed [fcpu_pkg::POS_W-1:0] pos_x_reg;
    logic signed [fcpu_pkg::POS_W-1:0] pos_y_reg;
    logic signed [fcpu_pkg::POS_W-1:0] pos_z_reg;
    logic [fcpu_pkg::ANG_W-1:0]        pitch_reg;
    logic [fcpu_pkg::ANG_W-1:0]        yaw_reg;

    logic signed [fcpu_pkg::POS_W-1:0] pos_x_next;
    logic signed [fcpu_pkg::POS_W-1:0] pos_y_next;
    logic signed [fcpu_pkg::POS_W-1:0] pos_z_next;
    logic [fcpu_pkg::ANG_W-1:0]        pitch_next;
    logic [fcpu_pkg::ANG_W-1:0]        yaw_next;

    logic signed [fcpu_pkg::WGT_W-1:0] sin_yaw;
    logic signed [fcpu_pkg::WGT_W-1:0] cos_yaw;
    logic signed [fcpu_pkg::WGT_W-1:0] sin_pitch;

    fcpu_pkg::axis_ctl_t               ctl_x;
    fcpu_pkg::axis_ctl_t               ctl_y;
    fcpu_pkg::axis_ctl_t               ctl_z;
    logic signed [fcpu_pkg::WGT_W-1:0] weight_x;
    logic signed [fcpu_pkg::WGT_W-1:0] weight_z;

    logic                              advance;
    logic                              is_move;

    // Advance the held command whenever the pose slot is free or being taken.
    assign advance   = cmd_vld_reg && (!out_vld_reg || pose.ready);
    assign cmd.ready = !cmd_vld_reg || advance;
    assign is_move   = (op_reg == fcpu_pkg::OP_MOVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_vld_reg <= cmd.valid;
        end
    end

    // Command payload: load on accept, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg     <= cmd.op;
            way_reg    <= cmd.way;
            amount_reg <= cmd.amount;
        end
    end

    // Trig samples of the angles as they will stand after this edge.
    fcpu_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin_yaw (
        .clk    (clk),
        .angle  (yaw_next),
        .sample (sin_yaw)
    );

    fcpu_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos_yaw (
        .clk    (clk),
        .angle  (yaw_next + fcpu_pkg::QUARTER_TURN),
        .sample (cos_yaw)
    );

    fcpu_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin_pitch (
        .clk    (clk),
        .angle  (pitch_next),
        .sample (sin_pitch)
    );

    // Steer weights and signs per axis from the move direction.
    always_comb
    begin
        ctl_x.en  = is_move;
        ctl_y.en  = is_move && !way_reg[1];
        ctl_z.en  = is_move;
        ctl_x.neg = (way_reg == fcpu_pkg::MOVE_FORWARD) || (way_reg == fcpu_pkg::MOVE_RIGHT);
        ctl_y.neg = (way_reg == fcpu_pkg::MOVE_BACKWARD);
        ctl_z.neg = (way_reg == fcpu_pkg::MOVE_BACKWARD) || (way_reg == fcpu_pkg::MOVE_RIGHT);
        weight_x  = way_reg[1] ? cos_yaw : sin_yaw;
        weight_z  = way_reg[1] ? sin_yaw : cos_yaw;
    end

    fcpu_axis_step u_step_x (
        .base   (pos_x_reg),
        .amount (amount_reg),
        .weight (weight_x),
        .ctl    (ctl_x),
        .result (pos_x_next)
    );

    fcpu_axis_step u_step_y (
        .base   (pos_y_reg),
        .amount (amount_reg),
        .weight (sin_pitch),
        .ctl    (ctl_y),
        .result (pos_y_next)
    );

    fcpu_axis_step u_step_z (
        .base   (pos_z_reg),
        .amount (amount_reg),
        .weight (weight_z),
        .ctl    (ctl_z),
        .result (pos_z_next)
    );

    // Angles wrap at 16 bits; hold them unless a rotate advances.
    always_comb
    begin
        pitch_next = pitch_reg;
        yaw_next   = yaw_reg;
        if (advance && !is_move)
        begin
            case (way_reg)
                fcpu_pkg::ROT_UP:    pitch_next = pitch_reg - amount_reg;
                fcpu_pkg::ROT_DOWN:  pitch_next = pitch_reg + amount_reg;
                fcpu_pkg::ROT_LEFT:  yaw_next   = yaw_reg - amount_reg;
                fcpu_pkg::ROT_RIGHT: yaw_next   = yaw_reg + amount_reg;
                default:             yaw_next   = yaw_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                pos_z_reg   <= pos_z_next;
            end
            else if (pose.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign pose.valid = out_vld_reg;
    assign pose.pos_x = pos_x_reg;
    assign pose.pos_y = pos_y_reg;
    assign pose.pos_z = pos_z_reg;
    assign pose.pitch = pitch_reg;
    assign pose.yaw   = yaw_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fcpu_checker.sv @@
// Port-level checks for fly_camera_pose_update, attached with a bind.
// Depends on fcpu_pkg for widths.
`default_nettype none

module fcpu_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_ready,
    input  logic                                pose_valid,
    input  logic                                pose_ready,
    input  logic signed [fcpu_pkg::POS_W-1:0]   pos_x,
    input  logic [fcpu_pkg::ANG_W-1:0]          pitch,
    input  logic [fcpu_pkg::ANG_W-1:0]          yaw
);

    // A stalled pose item stays valid.
    a_pose_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |=> pose_valid)
        else $error("pose item dropped while stalled");

    // A stalled pose item keeps its x position, pitch and yaw.
    a_pose_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |=> $stable(pos_x) && $stable(pitch) && $stable(yaw))
        else $error("pose payload changed while stalled");

    // Back-pressure on commands only comes from a stalled pose.
    a_cmd_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> pose_valid && !pose_ready)
        else $error("command stalled without output back-pressure");

    // The x position, pitch and yaw only change when a new pose item is presented.
    a_pose_change: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch != $past(pitch)) || (yaw != $past(yaw)) || (pos_x != $past(pos_x))
        |-> pose_valid)
        else $error("pose changed without a pose item");

endmodule

bind fly_camera_pose_update fcpu_checker u_fcpu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd.ready),
    .pose_valid (pose.valid),
    .pose_ready (pose.ready),
    .pos_x      (pose.pos_x),
    .pitch      (pose.pitch),
    .yaw        (pose.yaw)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for fly_camera_pose_update: drives move and rotate commands and checks every pose.
// Depends on fcpu_pkg, fcpu_cmd_if, fcpu_pose_if and the block itself.

module testbench;

    localparam int unsigned SINE_DEPTH  = fcpu_pkg::SINE_TABLE_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PRINT_LIMIT = 40;
    localparam longint     POS_MAX      = 64'sd2147483647;
    localparam longint     POS_MIN      = -64'sd2147483648;

    // One pose as the block reports it.
    typedef struct packed {
        logic signed [fcpu_pkg::POS_W-1:0] x;
        logic signed [fcpu_pkg::POS_W-1:0] y;
        logic signed [fcpu_pkg::POS_W-1:0] z;
        logic [fcpu_pkg::ANG_W-1:0]        pitch;
        logic [fcpu_pkg::ANG_W-1:0]        yaw;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n;

    fcpu_cmd_if  cmd_if ();
    fcpu_pose_if pose_if ();

    fly_camera_pose_update #(
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .pose  (pose_if)
    );

    // Camera state as it should stand after every accepted command.
    logic signed [fcpu_pkg::POS_W-1:0] cam_x;
    logic signed [fcpu_pkg::POS_W-1:0] cam_y;
    logic signed [fcpu_pkg::POS_W-1:0] cam_z;
    logic [fcpu_pkg::ANG_W-1:0]        cam_pitch;
    logic [fcpu_pkg::ANG_W-1:0]        cam_yaw;

    pose_t       pending_poses[$];
    pose_t       oldest_pose;
    int unsigned error_count;
    int unsigned pose_count;
    int unsigned cycle_count;
    bit          steady_flow;

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop for a block that hangs or stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pose predictor
    // ------------------------------------------------------------------

    // Quarter-wave polynomial: Q1.15 sine of a sample angle.
    function automatic int quarter_wave(input logic [fcpu_pkg::ANG_W-1:0] angle);
        bit [31:0] frac;
        bit [31:0] frac_sq;
        bit [31:0] series;
        bit [31:0] level;
        frac = {18'd0, angle[13:0]};
        // Mirror the odd quadrants so the series always runs up from zero.
        if (angle[14])
        begin
            frac = 32'd16384 - frac;
        end
        frac_sq = (frac * frac) >> 14;
        series  = 32'd10581 - ((frac_sq * 32'd1229) >> 14);
        series  = 32'd25736 - ((frac_sq * series) >> 14);
        level   = (frac * series) >> 13;
        if (level > 32'd32767)
        begin
            level = 32'd32767;
        end
        return angle[15] ? -int'(level) : int'(level);
    endfunction

    // Snap the angle down to the nearest table sample, then evaluate.
    function automatic int sampled_sine(input logic [fcpu_pkg::ANG_W-1:0] angle);
        longint unsigned slot;
        longint unsigned sample;
        slot   = (longint'(angle) * SINE_DEPTH) >> 16;
        sample = (slot * 65536) / SINE_DEPTH;
        return quarter_wave(sample[15:0]);
    endfunction

    // Q8.8 magnitude times Q1.15 weight, rounded to Q16.16.
    function automatic longint weighted_step(input int magnitude, input int weight);
        longint product;
        product = longint'(magnitude) * longint'(weight);
        return (product + 64) >>> 7;
    endfunction

    function automatic logic signed [fcpu_pkg::POS_W-1:0] clamp_add(
        input logic signed [fcpu_pkg::POS_W-1:0] base,
        input longint step);
        longint total;
        total = longint'(base) + step;
        if (total > POS_MAX)
        begin
            total = POS_MAX;
        end
        else if (total < POS_MIN)
        begin
            total = POS_MIN;
        end
        return total[fcpu_pkg::POS_W-1:0];
    endfunction

    // Advance the camera by one accepted command and queue the pose it must produce.
    task automatic apply_command(input logic op, input logic [1:0] way,
                                 input logic signed [fcpu_pkg::AMT_W-1:0] amount);
        int    ahead;
        int    back;
        int    yaw_sin;
        int    yaw_cos;
        int    pitch_sin;
        pose_t next_pose;
        ahead     = int'(amount);
        back      = -ahead;
        yaw_sin   = sampled_sine(cam_yaw);
        yaw_cos   = sampled_sine(cam_yaw + fcpu_pkg::QUARTER_TURN);
        pitch_sin = sampled_sine(cam_pitch);
        if (op == fcpu_pkg::OP_MOVE)
        begin
            case (way)
                fcpu_pkg::MOVE_FORWARD:
                begin
                    cam_x = clamp_add(cam_x, weighted_step(back, yaw_sin));
                    cam_y = clamp_add(cam_y, weighted_step(ahead, pitch_sin));
                    cam_z = clamp_add(cam_z, weighted_step(ahead, yaw_cos));
                end
                fcpu_pkg::MOVE_BACKWARD:
                begin
                    cam_x = clamp_add(cam_x, weighted_step(ahead, yaw_sin));
                    cam_y = clamp_add(cam_y, weighted_step(back, pitch_sin));
                    cam_z = clamp_add(cam_z, weighted_step(back, yaw_cos));
                end
                fcpu_pkg::MOVE_LEFT:
                begin
                    cam_x = clamp_add(cam_x, weighted_step(ahead, yaw_cos));
                    cam_z = clamp_add(cam_z, weighted_step(ahead, yaw_sin));
                end
                default:
                begin
                    cam_x = clamp_add(cam_x, weighted_step(back, yaw_cos));
                    cam_z = clamp_add(cam_z, weighted_step(back, yaw_sin));
                end
            endcase
        end
        else
        begin
            case (way)
                fcpu_pkg::ROT_UP:   cam_pitch = cam_pitch - amount;
                fcpu_pkg::ROT_DOWN: cam_pitch = cam_pitch + amount;
                fcpu_pkg::ROT_LEFT: cam_yaw   = cam_yaw - amount;
                default:            cam_yaw   = cam_yaw + amount;
            endcase
        end
        next_pose.x     = cam_x;
        next_pose.y     = cam_y;
        next_pose.z     = cam_z;
        next_pose.pitch = cam_pitch;
        next_pose.yaw   = cam_yaw;
        pending_poses.push_back(next_pose);
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Drive one item and hold it until accepted. Returns at the accepting edge with
    // valid still high; the next send or settle_pipeline takes it from there.
    task automatic send_command(input logic op, input logic [1:0] way,
                                input logic signed [fcpu_pkg::AMT_W-1:0] amount);
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < 15)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.op     <= op;
        cmd_if.way    <= way;
        cmd_if.amount <= amount;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        apply_command(op, way, amount);
    endtask

    // Drop valid and wait for every queued pose, then let stragglers drain.
    task automatic settle_pipeline();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (pending_poses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Pose side
    // ------------------------------------------------------------------

    // Stall the pose channel about 15 percent of the time, except in steady stretches.
    always @(negedge clk)
    begin
        pose_if.ready <= steady_flow || ($urandom_range(0, 99) >= 15);
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (error_count < PRINT_LIMIT)
        begin
            $display("pose %0d: %s expected %0d got %0d", pose_count, what, want, got);
        end
        error_count++;
    endtask

    // Compare each delivered pose with the oldest one still owed.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pose_if.valid === 1'b1 && pose_if.ready === 1'b1)
        begin
            if (pending_poses.size() == 0)
            begin
                report_mismatch("unexpected pose, none owed", 0, 0);
            end
            else
            begin
                oldest_pose = pending_poses.pop_front();
                if (pose_if.pos_x !== oldest_pose.x)
                    report_mismatch("pos_x", oldest_pose.x, pose_if.pos_x);
                if (pose_if.pos_y !== oldest_pose.y)
                    report_mismatch("pos_y", oldest_pose.y, pose_if.pos_y);
                if (pose_if.pos_z !== oldest_pose.z)
                    report_mismatch("pos_z", oldest_pose.z, pose_if.pos_z);
                if (pose_if.pitch !== oldest_pose.pitch)
                    report_mismatch("pitch", oldest_pose.pitch, pose_if.pitch);
                if (pose_if.yaw !== oldest_pose.yaw)
                    report_mismatch("yaw", oldest_pose.yaw, pose_if.yaw);
            end
            pose_count++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A zero magnitude leaves the pose alone but must still report it.
    task automatic test_zero_magnitude();
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_FORWARD, 16'sd0);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_RIGHT, 16'sd0);
        settle_pipeline();
    endtask

    // Every rotate way, both sign extremes, and wrap through zero.
    task automatic test_rotate_ways();
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_UP, 16'sd1);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_DOWN, 16'sh7FFF);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_DOWN, 16'sh8000);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_LEFT, 16'sh7FFF);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_RIGHT, 16'sh8000);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_RIGHT, 16'sd1);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_UP, -16'sd1);
        settle_pipeline();
    endtask

    // Every move way at extreme and unit magnitudes; left and right must not touch y.
    task automatic test_move_ways();
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_DOWN, 16'sd9000);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_RIGHT, 16'sd12345);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_FORWARD, 16'sh7FFF);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_BACKWARD, 16'sh8000);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_LEFT, 16'sd1);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_RIGHT, -16'sd1);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_FORWARD, -16'sd1);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_BACKWARD, 16'sd256);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_LEFT, 16'sh8000);
        send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_RIGHT, 16'sh7FFF);
        settle_pipeline();
    endtask

    // Drive y and z into both saturation limits and x into its upper one, with no idling on either side.
    task automatic test_position_saturation();
        steady_flow = 1'b1;
        // Face straight ahead and pitch a quarter turn so forward moves feed y and z fully.
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_RIGHT, -cam_yaw);
        send_command(fcpu_pkg::OP_ROTATE, fcpu_pkg::ROT_DOWN,
                     fcpu_pkg::QUARTER_TURN - cam_pitch);
        repeat (300) send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_FORWARD, 16'sh7FFF);
        repeat (560) send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_FORWARD, 16'sh8000);
        // At zero yaw a left move drives x alone.
        repeat (280) send_command(fcpu_pkg::OP_MOVE, fcpu_pkg::MOVE_LEFT, 16'sh7FFF);
        settle_pipeline();
        steady_flow = 1'b0;
    endtask

    // Mostly full-range magnitudes, plus small steps and the extremes.
    function automatic logic signed [fcpu_pkg::AMT_W-1:0] pick_amount();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            return fcpu_pkg::AMT_W'($urandom);
        end
        else if (pick < 8)
        begin
            return fcpu_pkg::AMT_W'(int'($urandom_range(0, 512)) - 256);
        end
        case ($urandom_range(0, 3))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    task automatic test_random_commands(input int unsigned count);
        repeat (count)
        begin
            send_command(1'($urandom), 2'($urandom), pick_amount());
        end
        settle_pipeline();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.op      = fcpu_pkg::OP_MOVE;
        cmd_if.way     = fcpu_pkg::MOVE_FORWARD;
        cmd_if.amount  = '0;
        pose_if.ready  = 1'b0;
        steady_flow    = 1'b0;
        error_count    = 0;
        pose_count     = 0;
        cycle_count    = 0;
        cam_x          = '0;
        cam_y          = '0;
        cam_z          = '0;
        cam_pitch      = '0;
        cam_yaw        = '0;

        // Hold reset, then release it away from the rising edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_magnitude();
        test_rotate_ways();
        test_move_ways();
        test_position_saturation();
        test_random_commands(740);

        if (error_count == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
